// ----- design/hrhp_pkg.sv -----
// shared types, codes and character constants for the http request header parser
// no dependencies
`default_nettype none

package hrhp_pkg;

    localparam int VERSION_BITS_DEF = 16;
    localparam int OUT_VER_W        = 16;

    typedef enum logic [0:0] {
        OP_BYTE    = 1'b0,
        OP_RESTART = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STAT_BUSY = 2'd0,
        STAT_DONE = 2'd1,
        STAT_BAD  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        KIND_NONE       = 3'd0,
        KIND_METHOD     = 3'd1,
        KIND_URI        = 3'd2,
        KIND_NAME_FIRST = 3'd3,
        KIND_NAME       = 3'd4,
        KIND_VALUE      = 3'd5
    } kind_t;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_CTL_MAX   = 8'h1f;
    localparam logic [7:0] CH_ASCII_MAX = 8'h7f;
    localparam int         DIGIT_BASE   = 10;

    typedef struct packed {
        op_t        op;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        status_t               status;
        kind_t                 char_kind;
        logic [7:0]            char_value;
        logic [OUT_VER_W-1:0]  version_major;
        logic [OUT_VER_W-1:0]  version_minor;
    } out_item_t;

    typedef struct packed {
        logic token;
        logic control;
        logic digit;
        logic space_tab;
    } char_class_t;

endpackage

`default_nettype wire

// ----- design/hrhp_class.sv -----
// character classifier: token, control, digit and blank tests on one byte
// depends on hrhp_pkg
`default_nettype none

module hrhp_class (
    input  wire logic [7:0]          byte_value,
    output hrhp_pkg::char_class_t    cls
);

    logic separator;
    logic ascii;

    always_comb
    begin
        unique case (byte_value)
            8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40,
            8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
            8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d,
            8'h7b, 8'h7d, 8'h20, 8'h09: separator = 1'b1;
            default:                    separator = 1'b0;
        endcase
    end

    assign ascii         = (byte_value <= hrhp_pkg::CH_ASCII_MAX);
    assign cls.control   = (byte_value <= hrhp_pkg::CH_CTL_MAX) ||
                           (byte_value == hrhp_pkg::CH_DEL);
    assign cls.token     = ascii && !cls.control && !separator;
    assign cls.digit     = (byte_value >= hrhp_pkg::CH_ZERO) &&
                           (byte_value <= hrhp_pkg::CH_NINE);
    assign cls.space_tab = (byte_value == hrhp_pkg::CH_SP) ||
                           (byte_value == hrhp_pkg::CH_TAB);

endmodule

`default_nettype wire

// ----- design/hrhp_core.sv -----
// parse state machine, version counters and result register
// depends on hrhp_pkg and hrhp_class
`default_nettype none

module hrhp_core #(
    parameter int VERSION_BITS = hrhp_pkg::VERSION_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire hrhp_pkg::in_item_t  item,
    output hrhp_pkg::out_item_t      result
);

    localparam int OW = hrhp_pkg::OUT_VER_W;

    typedef enum logic [4:0] {
        ST_METHOD_START = 5'd0,
        ST_METHOD       = 5'd1,
        ST_URI          = 5'd2,
        ST_VER_H        = 5'd3,
        ST_VER_T1       = 5'd4,
        ST_VER_T2       = 5'd5,
        ST_VER_P        = 5'd6,
        ST_VER_SLASH    = 5'd7,
        ST_MAJOR_START  = 5'd8,
        ST_MAJOR        = 5'd9,
        ST_MINOR_START  = 5'd10,
        ST_MINOR        = 5'd11,
        ST_NL1          = 5'd12,
        ST_LINE_START   = 5'd13,
        ST_LWS          = 5'd14,
        ST_NAME         = 5'd15,
        ST_SPACE_VALUE  = 5'd16,
        ST_VALUE        = 5'd17,
        ST_NL2          = 5'd18,
        ST_NL3          = 5'd19
    } state_t;

    state_t                   state_reg, state_next;
    logic                     header_seen_reg, header_seen_next;
    logic [VERSION_BITS-1:0]  major_reg, major_next;
    logic [VERSION_BITS-1:0]  minor_reg, minor_next;
    hrhp_pkg::out_item_t      result_reg, result_next;

    hrhp_pkg::char_class_t    cls;
    hrhp_pkg::status_t        st;
    hrhp_pkg::kind_t          kind;
    logic [7:0]               b;
    logic [VERSION_BITS+OW-1:0] major_ext, minor_ext;

    function automatic logic [VERSION_BITS-1:0] add_digit(
        input logic [VERSION_BITS-1:0] v,
        input logic [7:0]              d
    );
        logic [VERSION_BITS+3:0] n;
        logic [VERSION_BITS+3:0] top;
        top = {4'b0, {VERSION_BITS{1'b1}}};
        n   = ({4'b0, v} << 3) + ({4'b0, v} << 1) +
              {{(VERSION_BITS){1'b0}}, d[3:0] - hrhp_pkg::CH_ZERO[3:0]};
        return (n > top) ? {VERSION_BITS{1'b1}} : n[VERSION_BITS-1:0];
    endfunction

    assign b = item.byte_value;

    hrhp_class u_class (
        .byte_value (b),
        .cls        (cls)
    );

    always_comb
    begin
        state_next       = state_reg;
        header_seen_next = header_seen_reg;
        major_next       = major_reg;
        minor_next       = minor_reg;
        st               = hrhp_pkg::STAT_BUSY;
        kind             = hrhp_pkg::KIND_NONE;
        if (item.op == hrhp_pkg::OP_RESTART)
        begin
            state_next       = ST_METHOD_START;
            header_seen_next = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_METHOD_START:
                    if (cls.token)
                    begin
                        state_next = ST_METHOD;
                        kind       = hrhp_pkg::KIND_METHOD;
                    end
                    else
                        st = hrhp_pkg::STAT_BAD;
                ST_METHOD:
                    priority if (b == hrhp_pkg::CH_SP) state_next = ST_URI;
                    else if (cls.token) kind = hrhp_pkg::KIND_METHOD;
                    else st = hrhp_pkg::STAT_BAD;
                ST_URI:
                    priority if (b == hrhp_pkg::CH_SP) state_next = ST_VER_H;
                    else if (cls.control) st = hrhp_pkg::STAT_BAD;
                    else kind = hrhp_pkg::KIND_URI;
                ST_VER_H:
                    if (b == hrhp_pkg::CH_H) state_next = ST_VER_T1;
                    else st = hrhp_pkg::STAT_BAD;
                ST_VER_T1:
                    if (b == hrhp_pkg::CH_T) state_next = ST_VER_T2;
                    else st = hrhp_pkg::STAT_BAD;
                ST_VER_T2:
                    if (b == hrhp_pkg::CH_T) state_next = ST_VER_P;
                    else st = hrhp_pkg::STAT_BAD;
                ST_VER_P:
                    if (b == hrhp_pkg::CH_P) state_next = ST_VER_SLASH;
                    else st = hrhp_pkg::STAT_BAD;
                ST_VER_SLASH:
                    if (b == hrhp_pkg::CH_SLASH)
                    begin
                        major_next = '0;
                        minor_next = '0;
                        state_next = ST_MAJOR_START;
                    end
                    else
                        st = hrhp_pkg::STAT_BAD;
                ST_MAJOR_START:
                    if (cls.digit)
                    begin
                        major_next = add_digit(major_reg, b);
                        state_next = ST_MAJOR;
                    end
                    else
                        st = hrhp_pkg::STAT_BAD;
                ST_MAJOR:
                    priority if (b == hrhp_pkg::CH_DOT) state_next = ST_MINOR_START;
                    else if (cls.digit) major_next = add_digit(major_reg, b);
                    else st = hrhp_pkg::STAT_BAD;
                ST_MINOR_START:
                    if (cls.digit)
                    begin
                        minor_next = add_digit(minor_reg, b);
                        state_next = ST_MINOR;
                    end
                    else
                        st = hrhp_pkg::STAT_BAD;
                ST_MINOR:
                    priority if (b == hrhp_pkg::CH_CR) state_next = ST_NL1;
                    else if (cls.digit) minor_next = add_digit(minor_reg, b);
                    else st = hrhp_pkg::STAT_BAD;
                ST_NL1:
                    if (b == hrhp_pkg::CH_LF) state_next = ST_LINE_START;
                    else st = hrhp_pkg::STAT_BAD;
                ST_LINE_START:
                    priority if (b == hrhp_pkg::CH_CR) state_next = ST_NL3;
                    else if (header_seen_reg && cls.space_tab) state_next = ST_LWS;
                    else if (cls.token)
                    begin
                        header_seen_next = 1'b1;
                        kind             = hrhp_pkg::KIND_NAME_FIRST;
                        state_next       = ST_NAME;
                    end
                    else
                        st = hrhp_pkg::STAT_BAD;
                ST_LWS:
                    priority if (b == hrhp_pkg::CH_CR) state_next = ST_NL2;
                    else if (cls.space_tab) state_next = ST_LWS;
                    else if (cls.control) st = hrhp_pkg::STAT_BAD;
                    else
                    begin
                        state_next = ST_VALUE;
                        kind       = hrhp_pkg::KIND_VALUE;
                    end
                ST_NAME:
                    priority if (b == hrhp_pkg::CH_COLON) state_next = ST_SPACE_VALUE;
                    else if (cls.token) kind = hrhp_pkg::KIND_NAME;
                    else st = hrhp_pkg::STAT_BAD;
                ST_SPACE_VALUE:
                    if (b == hrhp_pkg::CH_SP) state_next = ST_VALUE;
                    else st = hrhp_pkg::STAT_BAD;
                ST_VALUE:
                    priority if (b == hrhp_pkg::CH_CR) state_next = ST_NL2;
                    else if (cls.control) st = hrhp_pkg::STAT_BAD;
                    else kind = hrhp_pkg::KIND_VALUE;
                ST_NL2:
                    if (b == hrhp_pkg::CH_LF) state_next = ST_LINE_START;
                    else st = hrhp_pkg::STAT_BAD;
                ST_NL3:
                    st = (b == hrhp_pkg::CH_LF) ? hrhp_pkg::STAT_DONE
                                                : hrhp_pkg::STAT_BAD;
                default:
                    st = hrhp_pkg::STAT_BAD;
            endcase
            // a bad byte leaves the parse state, header flag and version counters untouched
            if (st == hrhp_pkg::STAT_BAD)
            begin
                state_next       = state_reg;
                header_seen_next = header_seen_reg;
                major_next       = major_reg;
                minor_next       = minor_reg;
            end
        end
    end

    assign major_ext = {{OW{1'b0}}, major_next};
    assign minor_ext = {{OW{1'b0}}, minor_next};

    always_comb
    begin
        result_next.status        = st;
        result_next.char_kind     = kind;
        result_next.char_value    = (item.op == hrhp_pkg::OP_RESTART) ? 8'd0 : b;
        result_next.version_major = major_ext[OW-1:0];
        result_next.version_minor = minor_ext[OW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_METHOD_START;
            header_seen_reg <= 1'b0;
            major_reg       <= '0;
            minor_reg       <= '0;
            result_reg      <= '0;
        end
        else if (advance)
        begin
            state_reg       <= state_next;
            header_seen_reg <= header_seen_next;
            major_reg       <= major_next;
            minor_reg       <= minor_next;
            result_reg      <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ----- design/http_request_header_parser.sv -----
// http/1.1 request header parser, one request byte per item
// usage:
//   item channel (item_valid, item_stall, item) carries an op and a request byte;
//   op restart sends the parser back to the method state and clears the header flag.
//   result channel (result_valid, result_stall, result) returns one item per input
//   item: status, part tag, the byte and the running http version numbers.
//   path: an accepted item goes through the input register, then the state machine into
//   the result register, and result_valid rises when that register is written.
//   throughput: one item per cycle unless stalled; parse state steps once per byte.
//   stalls: when result_stall holds and both stages are full, item_stall rises;
//   a waiting result stays stable until taken and nothing is dropped.
//   reset (rst_n low, asynchronous): both stages empty, parser at method start,
//   header flag and version counters cleared.
// depends on hrhp_pkg and hrhp_core
`default_nettype none

module http_request_header_parser #(
    parameter int VERSION_BITS = hrhp_pkg::VERSION_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire hrhp_pkg::in_item_t  item,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output hrhp_pkg::out_item_t      result
);

    logic                 in_valid_reg;
    hrhp_pkg::in_item_t   in_item_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 advance;
    logic                 take;

    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign take       = item_valid && !item_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_item_reg <= item;
    end

    hrhp_core #(
        .VERSION_BITS (VERSION_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire
